[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the encoder checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define QRDS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qrds assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define QRDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qrds assertion failed");

`endif

[sv/qrds_pkg.sv]
// ---------------------------------------------------------------------------
// QR data segment encoder package
// Types, constants and lookup functions shared by the encoder modules.
// ---------------------------------------------------------------------------
package qrds_pkg;

  localparam int unsigned MaxWords = 4;
  localparam int unsigned WordIdxW = $clog2(MaxWords);
  localparam int unsigned WordCntW = $clog2(MaxWords + 1);
  localparam logic [14:0] BitsMax  = 15'h7FFF;

  typedef enum logic [1:0] {
    MODE_NUMERIC = 2'd0,
    MODE_ALNUM   = 2'd1,
    MODE_BYTE    = 2'd2,
    MODE_KANJI   = 2'd3
  } qrds_mode_e;

  typedef enum logic [1:0] {
    CFG_MODE     = 2'd0,
    CFG_VERSION  = 2'd1,
    CFG_COUNT    = 2'd2,
    CFG_CAPACITY = 2'd3
  } qrds_cfg_idx_e;

  typedef struct packed {
    qrds_mode_e  mode;
    logic [5:0]  version;
    logic [12:0] char_count;
    logic [14:0] capacity_bits;
  } qrds_cfg_t;

  typedef struct packed {
    logic        header_sent;
    logic [1:0]  group_fill;
    logic [9:0]  group_accum;
    logic [14:0] bits_used;
  } qrds_state_t;

  typedef struct packed {
    logic [12:0] value;
    logic [4:0]  bits;
    logic        last;
    logic        ovf;
  } qrds_word_t;

  function automatic logic [3:0] mode_ind(qrds_mode_e m);
    logic [3:0] r;
    unique case (m)
      MODE_NUMERIC: r = 4'd1;
      MODE_ALNUM:   r = 4'd2;
      MODE_BYTE:    r = 4'd4;
      MODE_KANJI:   r = 4'd8;
    endcase
    return r;
  endfunction

  // Character count indicator width by mode and version band
  function automatic logic [4:0] count_width(qrds_mode_e m, logic [5:0] ver);
    logic [1:0] band;
    logic [4:0] r;
    band = (ver <= 6'd9) ? 2'd0 : ((ver <= 6'd26) ? 2'd1 : 2'd2);
    unique case (m)
      MODE_NUMERIC: r = (band == 2'd0) ? 5'd10 : ((band == 2'd1) ? 5'd12 : 5'd14);
      MODE_ALNUM:   r = (band == 2'd0) ? 5'd9  : ((band == 2'd1) ? 5'd11 : 5'd13);
      MODE_BYTE:    r = (band == 2'd0) ? 5'd8  : 5'd16;
      MODE_KANJI:   r = (band == 2'd0) ? 5'd8  : ((band == 2'd1) ? 5'd10 : 5'd12);
    endcase
    return r;
  endfunction

  // Non-digits count as zero
  function automatic logic [3:0] digit_of(logic [7:0] b);
    logic [7:0] d;
    d = b - 8'h30;
    return (b >= 8'h30 && b <= 8'h39) ? d[3:0] : 4'd0;
  endfunction

  // 45-symbol alphanumeric table, unknown symbols map to zero
  function automatic logic [5:0] alnum_of(logic [7:0] b);
    logic [7:0] d;
    logic [7:0] u;
    logic [5:0] r;
    d = b - 8'h30;
    u = b - 8'h37;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = d[5:0];
    end else if (b >= 8'h41 && b <= 8'h5A) begin
      r = u[5:0];
    end else begin
      unique case (b)
        8'h20:   r = 6'd36;
        8'h24:   r = 6'd37;
        8'h25:   r = 6'd38;
        8'h2A:   r = 6'd39;
        8'h2B:   r = 6'd40;
        8'h2D:   r = 6'd41;
        8'h2E:   r = 6'd42;
        8'h2F:   r = 6'd43;
        8'h3A:   r = 6'd44;
        default: r = 6'd0;
      endcase
    end
    return r;
  endfunction

  // Shift-JIS to 13-bit kanji value; codes outside both ranges pass unshifted
  function automatic logic [12:0] kanji_of(logic [15:0] code);
    logic [15:0] c;
    logic [16:0] s;
    if (code >= 16'd33088 && code <= 16'd40956) begin
      c = code - 16'd33088;
    end else if (code >= 16'd57408 && code <= 16'd60351) begin
      c = code - 16'd49472;
    end else begin
      c = code;
    end
    s = ({9'd0, c[15:8]} * 17'd192) + {9'd0, c[7:0]};
    return s[12:0];
  endfunction

endpackage

[sv/qrds_in_if.sv]
// ---------------------------------------------------------------------------
// Message byte stream interface
// Valid/ready channel carrying one message byte and its end marker.
// ---------------------------------------------------------------------------
interface qrds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

[sv/qrds_out_if.sv]
// ---------------------------------------------------------------------------
// Bit-field word stream interface
// Valid/ready channel carrying one right-aligned bit field and its flags.
// ---------------------------------------------------------------------------
interface qrds_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] word_value;
  logic [4:0]  word_bits;
  logic        last_word;
  logic        overflow;

  modport source (output valid, output word_value, output word_bits, output last_word,
                  output overflow, input ready);
  modport sink   (input valid, input word_value, input word_bits, input last_word,
                  input overflow, output ready);
endinterface

[sv/qr_data_segment_encoder_top.sv]
// ---------------------------------------------------------------------------
// QR data segment encoder, top level
// Packs message bytes into QR bit-field words by the configured mode.
// ---------------------------------------------------------------------------
// Each accepted byte produces zero to four words, handed out one per output
// transaction. A byte that only extends a partial group yields no word, and
// a byte that yields a single word (byte mode, or a completed numeric,
// alphanumeric or kanji group) frees the buffer as its word leaves, so a
// steady stream runs at one byte per cycle while the output is not stalled.
// The first byte of a message adds the mode indicator and count words. The
// final byte adds the flushed partial group and the terminator (or overflow)
// word. The word buffer hands out a single word per cycle while the output
// is ready. A new byte is taken in the same cycle that the previous byte's
// last word leaves, and the new byte's words appear in the cycle after.
// Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i only
// while the block is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module qr_data_segment_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  qrds_in_if.sink     in_i,
  qrds_out_if.source  out_o
);
  import qrds_pkg::*;

  qrds_cfg_t                 cfg_q;
  qrds_state_t               state_q;
  qrds_state_t               state_d;
  qrds_word_t [MaxWords-1:0] words;
  logic [WordCntW-1:0]       word_cnt;
  logic                      buf_ready;
  logic                      accept;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_BYTE, version: 6'd1, char_count: 13'd0, capacity_bits: 15'd152};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:     cfg_q.mode          <= qrds_mode_e'(cfg_data_i[1:0]);
        CFG_VERSION:  cfg_q.version       <= cfg_data_i[5:0];
        CFG_COUNT:    cfg_q.char_count    <= cfg_data_i[12:0];
        CFG_CAPACITY: cfg_q.capacity_bits <= cfg_data_i;
        default:      cfg_q               <= cfg_q;
      endcase
    end
  end

  // Accept a byte whenever the word buffer frees up by the next edge
  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid & buf_ready;

  qrds_field_gen u_field_gen (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .char_byte_i (in_i.char_byte),
    .last_byte_i (in_i.last_byte),
    .words_o     (words),
    .count_o     (word_cnt),
    .state_o     (state_d)
  );

  // Segment state: header flag, partial group and running bit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  qrds_word_buf u_word_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .words_i (words),
    .count_i (word_cnt),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule

[sv/qrds_field_gen.sv]
// ---------------------------------------------------------------------------
// Field generator
// Turns one message byte and the segment state into up to four bit-field
// words and the next segment state.
// ---------------------------------------------------------------------------
module qrds_field_gen (
  input  qrds_pkg::qrds_cfg_t                             cfg_i,
  input  qrds_pkg::qrds_state_t                           state_i,
  input  logic [7:0]                                      char_byte_i,
  input  logic                                            last_byte_i,
  output qrds_pkg::qrds_word_t [qrds_pkg::MaxWords-1:0]   words_o,
  output logic [qrds_pkg::WordCntW-1:0]                   count_o,
  output qrds_pkg::qrds_state_t                           state_o
);
  import qrds_pkg::*;

  logic [WordCntW-1:0] n;
  logic [5:0]          add_bits;
  logic [4:0]          cw;
  logic [12:0]         cmask;
  logic [1:0]          fill;
  logic [9:0]          accum;
  logic [13:0]         num_prod;
  logic [9:0]          num_acc;
  logic [15:0]         aln_prod;
  logic [10:0]         aln_val;
  logic [15:0]         kcode;
  logic [12:0]         kval;
  logic [15:0]         bu_sum;
  logic [14:0]         bu_sat;
  logic [14:0]         rem;

  assign cw       = count_width(cfg_i.mode, cfg_i.version);
  assign cmask    = ~(13'h1FFF << cw);
  assign num_prod = {4'd0, state_i.group_accum} * 14'd10;
  assign num_acc  = num_prod[9:0] + {6'd0, digit_of(char_byte_i)};
  assign aln_prod = {6'd0, state_i.group_accum} * 16'd45;
  assign aln_val  = aln_prod[10:0] + {5'd0, alnum_of(char_byte_i)};
  // Pair completes with this byte, or a lone first byte gets a zero low byte
  assign kcode    = (state_i.group_fill != 2'd0) ? {state_i.group_accum[7:0], char_byte_i}
                                                 : {char_byte_i, 8'h00};
  assign kval     = kanji_of(kcode);

  always_comb begin
    words_o  = '0;
    n        = '0;
    add_bits = '0;
    fill     = state_i.group_fill;
    accum    = state_i.group_accum;
    bu_sum   = '0;
    bu_sat   = '0;
    rem      = '0;

    if (!state_i.header_sent) begin
      words_o[0] = '{value: {9'd0, mode_ind(cfg_i.mode)}, bits: 5'd4, last: 1'b0, ovf: 1'b0};
      words_o[1] = '{value: cfg_i.char_count & cmask, bits: cw, last: 1'b0, ovf: 1'b0};
      n          = WordCntW'(2);
      add_bits   = 6'd4 + {1'b0, cw};
    end

    unique case (cfg_i.mode)
      MODE_NUMERIC: begin
        if (fill >= 2'd2) begin
          words_o[n[WordIdxW-1:0]] = '{value: {3'd0, num_acc}, bits: 5'd10,
                                       last: 1'b0, ovf: 1'b0};
          n        = n + 1'b1;
          add_bits = add_bits + 6'd10;
          fill     = '0;
          accum    = '0;
        end else begin
          accum = num_acc;
          fill  = fill + 2'd1;
        end
      end
      MODE_ALNUM: begin
        if (fill >= 2'd1) begin
          words_o[n[WordIdxW-1:0]] = '{value: {2'd0, aln_val}, bits: 5'd11,
                                       last: 1'b0, ovf: 1'b0};
          n        = n + 1'b1;
          add_bits = add_bits + 6'd11;
          fill     = '0;
          accum    = '0;
        end else begin
          accum = {4'd0, alnum_of(char_byte_i)};
          fill  = 2'd1;
        end
      end
      MODE_BYTE: begin
        words_o[n[WordIdxW-1:0]] = '{value: {5'd0, char_byte_i}, bits: 5'd8,
                                     last: 1'b0, ovf: 1'b0};
        n        = n + 1'b1;
        add_bits = add_bits + 6'd8;
        fill     = '0;
        accum    = '0;
      end
      MODE_KANJI: begin
        if (fill >= 2'd1) begin
          words_o[n[WordIdxW-1:0]] = '{value: kval, bits: 5'd13, last: 1'b0, ovf: 1'b0};
          n        = n + 1'b1;
          add_bits = add_bits + 6'd13;
          fill     = '0;
          accum    = '0;
        end else begin
          accum = {2'd0, char_byte_i};
          fill  = 2'd1;
        end
      end
    endcase

    // Flush a partial group at the end of the message
    if (last_byte_i && fill != 2'd0) begin
      unique case (cfg_i.mode)
        MODE_NUMERIC: begin
          if (fill == 2'd1) begin
            words_o[n[WordIdxW-1:0]] = '{value: {9'd0, accum[3:0]}, bits: 5'd4,
                                         last: 1'b0, ovf: 1'b0};
            add_bits = add_bits + 6'd4;
          end else begin
            words_o[n[WordIdxW-1:0]] = '{value: {6'd0, accum[6:0]}, bits: 5'd7,
                                         last: 1'b0, ovf: 1'b0};
            add_bits = add_bits + 6'd7;
          end
          n = n + 1'b1;
        end
        MODE_ALNUM: begin
          words_o[n[WordIdxW-1:0]] = '{value: {7'd0, accum[5:0]}, bits: 5'd6,
                                       last: 1'b0, ovf: 1'b0};
          n        = n + 1'b1;
          add_bits = add_bits + 6'd6;
        end
        MODE_KANJI: begin
          words_o[n[WordIdxW-1:0]] = '{value: kval, bits: 5'd13, last: 1'b0, ovf: 1'b0};
          n        = n + 1'b1;
          add_bits = add_bits + 6'd13;
        end
        MODE_BYTE: begin
          n = n;
        end
      endcase
    end

    // Fold this item's bits into the running count, saturating
    bu_sum = {1'b0, state_i.bits_used} + {10'd0, add_bits};
    bu_sat = (bu_sum > {1'b0, BitsMax}) ? BitsMax : bu_sum[14:0];

    if (last_byte_i) begin
      if (bu_sat <= cfg_i.capacity_bits) begin
        rem = cfg_i.capacity_bits - bu_sat;
        words_o[n[WordIdxW-1:0]] = '{value: '0,
                                     bits: (rem >= 15'd4) ? 5'd4 : rem[4:0],
                                     last: 1'b1, ovf: 1'b0};
      end else begin
        words_o[n[WordIdxW-1:0]] = '{value: '0, bits: '0, last: 1'b1, ovf: 1'b1};
      end
      n       = n + 1'b1;
      state_o = '0;
    end else begin
      state_o = '{header_sent: 1'b1, group_fill: fill, group_accum: accum, bits_used: bu_sat};
    end

    count_o = n;
  end

endmodule

[sv/qrds_word_buf.sv]
// ---------------------------------------------------------------------------
// Word buffer
// Holds the words of one message byte and hands them out one per transaction.
// ---------------------------------------------------------------------------
module qrds_word_buf (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            load_i,
  input  qrds_pkg::qrds_word_t [qrds_pkg::MaxWords-1:0]   words_i,
  input  logic [qrds_pkg::WordCntW-1:0]                   count_i,
  output logic                                            ready_o,
  qrds_out_if.source                                      out_o
);
  import qrds_pkg::*;

  qrds_word_t [MaxWords-1:0] words_q;
  logic [WordCntW-1:0]       cnt_q;
  logic [WordIdxW-1:0]       idx_q;
  qrds_word_t                sel;
  logic                      drain;

  assign drain   = out_o.valid & out_o.ready;
  // Room next cycle: empty, or the last word leaves now
  assign ready_o = (cnt_q == '0) | ((cnt_q == WordCntW'(1)) & out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= count_i;
      idx_q <= '0;
    end else if (drain) begin
      cnt_q <= cnt_q - 1'b1;
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= words_i;
    end
  end

  assign sel              = words_q[idx_q];
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.word_value = sel.value;
  assign out_o.word_bits  = sel.bits;
  assign out_o.last_word  = sel.last;
  assign out_o.overflow   = sel.ovf;

endmodule

[sv/qrds_checker.sv]
// ---------------------------------------------------------------------------
// Encoder port checker
// Watches the top-level channels for word-stream and flow-control slips.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module qrds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [12:0] word_value_i,
  input logic [4:0]  word_bits_i,
  input logic        last_word_i,
  input logic        overflow_i
);

  // Hold a stalled word
  `QRDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable({word_value_i, word_bits_i, last_word_i, overflow_i}))

  // An empty output always takes a new byte
  `QRDS_ASSERT_IMPL(a_idle_ready, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // A stalled word blocks new bytes
  `QRDS_ASSERT_IMPL(a_stall_block, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i)

  // Overflow comes only as an empty final word
  `QRDS_ASSERT_IMPL(a_ovf_final, clk_i, rst_ni, out_valid_i && overflow_i, last_word_i && word_bits_i == 5'd0 && word_value_i == 13'd0)

  // Terminator is at most four zero bits
  `QRDS_ASSERT_IMPL(a_term_zero, clk_i, rst_ni, out_valid_i && last_word_i, word_value_i == 13'd0 && word_bits_i <= 5'd4)

endmodule

bind qr_data_segment_encoder_top qrds_checker u_qrds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .word_value_i (out_o.word_value),
  .word_bits_i  (out_o.word_bits),
  .last_word_i  (out_o.last_word),
  .overflow_i   (out_o.overflow)
);

[test/qrds_checker.sv]
// ---------------------------------------------------------------------------
// QR data segment encoder word checker
// Tracks configuration writes, predicts the bit-field words that every
// accepted message byte must produce and compares each output transaction
// with the oldest predicted word.
// ---------------------------------------------------------------------------
module qrds_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i,
  qrds_in_if          in_i,
  qrds_out_if         out_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  import qrds_pkg::*;

  localparam logic [8*45-1:0] AlnumSet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";
  localparam int unsigned SjisLowFirst  = 33088;
  localparam int unsigned SjisLowLast   = 40956;
  localparam int unsigned SjisHighFirst = 57408;
  localparam int unsigned SjisHighLast  = 60351;
  localparam int unsigned SjisHighShift = 49472;

  // configuration copy
  qrds_mode_e  mode_q;
  logic [5:0]  ver_q;
  logic [12:0] count_q;
  logic [14:0] cap_q;

  // segment state
  logic        hdr_sent;
  logic [1:0]  fill;
  logic [9:0]  accum;
  logic [14:0] bit_total;

  qrds_word_t  expected_words[$];
  int unsigned mismatches = 0;

  function automatic int unsigned digit_val(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) ? int'(b) - 'h30 : 0;
  endfunction

  function automatic int unsigned alnum_val(logic [7:0] b);
    for (int i = 0; i < 45; i++) begin
      if (AlnumSet[8*(44-i) +: 8] == b) return i;
    end
    return 0;
  endfunction

  // Shift-JIS code to 13-bit kanji index; codes outside both ranges stay as they are
  function automatic logic [12:0] sjis_index(logic [15:0] code);
    int unsigned c;
    c = code;
    if (c >= SjisLowFirst && c <= SjisLowLast) begin
      c = c - SjisLowFirst;
    end else if (c >= SjisHighFirst && c <= SjisHighLast) begin
      c = c - SjisHighShift;
    end
    return 13'((c >> 8) * 192 + (c & 'hFF));
  endfunction

  function automatic int unsigned cci_width(qrds_mode_e m, logic [5:0] ver);
    int unsigned band;
    band = (ver <= 9) ? 0 : ((ver <= 26) ? 1 : 2);
    case (m)
      MODE_NUMERIC: return 10 + 2 * band;
      MODE_ALNUM:   return 9 + 2 * band;
      MODE_BYTE:    return (band == 0) ? 8 : 16;
      default:      return 8 + 2 * band;
    endcase
  endfunction

  function automatic void emit_field(int unsigned val, int unsigned nbits, bit fin, bit ovf);
    qrds_word_t  w;
    int unsigned sum;
    w.value = 13'(val);
    w.bits  = 5'(nbits);
    w.last  = fin;
    w.ovf   = ovf;
    expected_words.push_back(w);
    sum = bit_total + nbits;
    bit_total = (sum > BitsMax) ? BitsMax : 15'(sum);
  endfunction

  function automatic void clear_group();
    fill  = '0;
    accum = '0;
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic fin);
    int unsigned acc;
    int unsigned w;
    int unsigned rem;
    if (!hdr_sent) begin
      w = cci_width(mode_q, ver_q);
      emit_field(1 << int'(mode_q), 4, 0, 0);
      emit_field(count_q & ((1 << w) - 1), w, 0, 0);
      hdr_sent = 1'b1;
    end
    case (mode_q)
      MODE_NUMERIC: begin
        acc = (accum * 10 + digit_val(b)) & 'h3FF;
        if (fill >= 2) begin
          emit_field(acc, 10, 0, 0);
          clear_group();
        end else begin
          accum = 10'(acc);
          fill  = fill + 1;
        end
      end
      MODE_ALNUM: begin
        if (fill >= 1) begin
          emit_field((accum * 45 + alnum_val(b)) & 'h7FF, 11, 0, 0);
          clear_group();
        end else begin
          accum = 10'(alnum_val(b));
          fill  = 2'd1;
        end
      end
      MODE_BYTE: begin
        emit_field(b, 8, 0, 0);
        clear_group();
      end
      default: begin
        if (fill >= 1) begin
          emit_field(sjis_index({accum[7:0], b}), 13, 0, 0);
          clear_group();
        end else begin
          accum = {2'b00, b};
          fill  = 2'd1;
        end
      end
    endcase
    if (fin) begin
      if (fill != 0) begin
        case (mode_q)
          MODE_NUMERIC: begin
            if (fill == 1) emit_field(accum & 'hF, 4, 0, 0);
            else emit_field(accum & 'h7F, 7, 0, 0);
          end
          MODE_ALNUM: emit_field(accum & 'h3F, 6, 0, 0);
          MODE_KANJI: emit_field(sjis_index({accum[7:0], 8'h00}), 13, 0, 0);
          default: ;
        endcase
      end
      if (bit_total <= cap_q) begin
        rem = cap_q - bit_total;
        emit_field(0, (rem >= 4) ? 4 : rem, 1, 0);
      end else begin
        emit_field(0, 0, 1, 1);
      end
      hdr_sent  = 1'b0;
      bit_total = '0;
      clear_group();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    qrds_word_t got;
    qrds_word_t want;
    if (!rst_ni) begin
      mode_q    = MODE_BYTE;
      ver_q     = 6'd1;
      count_q   = '0;
      cap_q     = 15'd152;
      hdr_sent  = 1'b0;
      bit_total = '0;
      clear_group();
      expected_words.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (qrds_cfg_idx_e'(cfg_idx_i))
          CFG_MODE:    mode_q  = qrds_mode_e'(cfg_data_i[1:0]);
          CFG_VERSION: ver_q   = cfg_data_i[5:0];
          CFG_COUNT:   count_q = cfg_data_i[12:0];
          default:     cap_q   = cfg_data_i;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        got.value = out_i.word_value;
        got.bits  = out_i.word_bits;
        got.last  = out_i.last_word;
        got.ovf   = out_i.overflow;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: value %0d bits %0d last %0b overflow %0b",
                   $time, got.value, got.bits, got.last, got.ovf);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (got != want) begin
            $display("%0t: word mismatch: expected value %0d bits %0d last %0b overflow %0b,",
                     $time, want.value, want.bits, want.last, want.ovf);
            $display("%0t:   actual value %0d bits %0d last %0b overflow %0b",
                     $time, got.value, got.bits, got.last, got.ovf);
            mismatches++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        encode_byte(in_i.char_byte, in_i.last_byte);
      end
      pending_o <= expected_words.size();
    end
    errors_o <= mismatches;
  end

endmodule

[test/tb_qr_data_segment_encoder_top.sv]
// ---------------------------------------------------------------------------
// QR data segment encoder testbench
// Drives message bytes through the encoder under every mode and a range of
// versions, counts and capacities, with random idle cycles on both channels;
// a checker beside the block predicts and compares every output word.
// ---------------------------------------------------------------------------
module tb_qr_data_segment_encoder_top;
  import qrds_pkg::*;

  localparam int unsigned SettleCycles = 8;      // quiet margin after the last word leaves
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned IdlePct      = 25;
  localparam logic [8*45-1:0] AlnumSet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ $%*+-./:";

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [14:0] cfg_data_i;
  bit          steady = 1'b0;   // suppress idling on both channels
  int unsigned cycles = 0;
  int unsigned pending;
  int unsigned errors;

  logic [5:0]  band_limits [8] = '{6'd0, 6'd1, 6'd9, 6'd10, 6'd26, 6'd27, 6'd40, 6'd63};

  qrds_in_if  in_ch ();
  qrds_out_if out_ch ();

  qr_data_segment_encoder_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  qrds_word_checker u_word_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_i      (out_ch),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the word stream at random unless a steady stretch is running
  always @(posedge clk_i) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IdlePct);
  end

  // Hard stop for a hung handshake or words that never arrive
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one byte, hold it until the transaction completes, then maybe
  // drop valid for a random gap with junk on the data lines.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= b;
    in_ch.last_byte <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (!steady && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid     <= 1'b0;
      in_ch.char_byte <= 8'($urandom);
      in_ch.last_byte <= 1'($urandom);
      do @(posedge clk_i); while ($urandom_range(0, 99) < IdlePct);
    end
  endtask

  // Drop valid and wait until every predicted word has left, plus a margin
  // for a byte that produced no word but may still be in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input qrds_cfg_idx_e idx, input logic [14:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic configure(input qrds_mode_e m, input logic [5:0] ver,
                           input logic [12:0] cnt, input logic [14:0] cap);
    drain();
    write_reg(CFG_MODE, 15'(m));
    write_reg(CFG_VERSION, 15'(ver));
    write_reg(CFG_COUNT, 15'(cnt));
    write_reg(CFG_CAPACITY, cap);
    cfg_we_i <= 1'b0;
  endtask

  // Switch mode in the middle of a message; the partial group is kept
  task automatic set_mode(input qrds_mode_e m);
    drain();
    write_reg(CFG_MODE, 15'(m));
    cfg_we_i <= 1'b0;
  endtask

  // Build a message of well-formed characters for the mode, salted with
  // junk bytes, and in kanji mode sometimes a dangling half character.
  task automatic send_message(input qrds_mode_e m, input int unsigned nchars);
    logic [7:0]  msg[$];
    logic [15:0] code;
    for (int i = 0; i < nchars; i++) begin
      if ($urandom_range(0, 99) < 10) begin
        msg.push_back(8'($urandom));
      end else begin
        case (m)
          MODE_NUMERIC: msg.push_back(8'h30 + 8'($urandom_range(0, 9)));
          MODE_ALNUM:   msg.push_back(AlnumSet[8*$urandom_range(0, 44) +: 8]);
          MODE_BYTE:    msg.push_back(8'($urandom));
          default: begin
            code = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(33088, 40956))
                                               : 16'($urandom_range(57408, 60351));
            msg.push_back(code[15:8]);
            msg.push_back(code[7:0]);
          end
        endcase
      end
    end
    if (m == MODE_KANJI && $urandom_range(0, 9) == 0) msg.push_back(8'($urandom));
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  initial begin
    qrds_mode_e  m;
    logic [5:0]  ver;
    logic [12:0] cnt;
    logic [14:0] cap;

    // Hold every input at a known value from time zero
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_MODE;
    cfg_data_i      = '0;
    in_ch.valid     = 1'b0;
    in_ch.char_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: byte mode, version 1, zero count, 152-bit capacity
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);

    // Numeric at version 0: a full triple, then a two-digit tail with a
    // non-digit, then a lone digit
    configure(MODE_NUMERIC, 6'd0, 13'd1023, 15'd200);
    send_byte("9", 1'b0);
    send_byte("9", 1'b0);
    send_byte("9", 1'b0);
    send_byte("1", 1'b0);
    send_byte("x", 1'b1);
    send_byte("7", 1'b1);

    // Alphanumeric above version 40: a pair, then an odd symbol outside the table
    configure(MODE_ALNUM, 6'd63, 13'h1FFF, 15'd100);
    send_byte("A", 1'b0);
    send_byte(":", 1'b0);
    send_byte("a", 1'b1);

    // Kanji: start of the low range, end of the high range, a code outside
    // both ranges, then a trailing half character
    configure(MODE_KANJI, 6'd26, 13'h1FFF, 15'h7FFF);
    send_byte(8'h81, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'hEB, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h93, 1'b1);

    // Capacity corners in byte mode: overflow, exact fit, short terminator
    configure(MODE_BYTE, 6'd1, 13'd1, 15'd0);
    send_byte(8'h5A, 1'b1);
    configure(MODE_BYTE, 6'd1, 13'd1, 15'd20);
    send_byte(8'hA5, 1'b1);
    configure(MODE_BYTE, 6'd1, 13'd1, 15'd22);
    send_byte(8'h3C, 1'b1);

    // Mode change mid-message: a half kanji finished as a numeric digit,
    // byte mode dropping the numeric group, alphanumeric odd tail
    configure(MODE_KANJI, 6'd10, 13'd3, 15'd200);
    send_byte(8'h81, 1'b0);
    set_mode(MODE_NUMERIC);
    send_byte("5", 1'b0);
    set_mode(MODE_BYTE);
    send_byte(8'h41, 1'b0);
    set_mode(MODE_ALNUM);
    send_byte("Z", 1'b1);

    // Random phases: fresh settings each time, one phase without idling
    for (int phase = 0; phase < 6; phase++) begin
      m   = (phase < 4) ? qrds_mode_e'(phase) : qrds_mode_e'($urandom_range(0, 3));
      ver = ($urandom_range(0, 3) == 0) ? 6'($urandom) : band_limits[$urandom_range(0, 7)];
      cnt = ($urandom_range(0, 3) == 0) ? 13'h1FFF : 13'($urandom);
      case ($urandom_range(0, 3))
        0:       cap = 15'($urandom_range(0, 40));
        1:       cap = 15'($urandom_range(40, 200));
        2:       cap = 15'h7FFF;
        default: cap = 15'($urandom);
      endcase
      configure(m, ver, cnt, cap);
      steady <= (phase == 3);
      for (int k = 0; k < 4; k++) begin
        send_message(m, $urandom_range(1, 8));
      end
    end
    steady <= 1'b0;

    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
